### rtl/core/dwm_pkg.sv
// ----------------------------------------------------------------------------
// dwm_pkg: shared constants for the drive / waveshaper / mix block
// Sample format, register map, mix constants and the tanh lookup table.
// ----------------------------------------------------------------------------
package dwm_pkg;

    localparam int SAMPLE_BITS      = 24;
    localparam int TANH_TABLE_DEPTH = 256;
    localparam int IDX_BITS         = $clog2(TANH_TABLE_DEPTH + 1);
    // fraction bits between table entries: |t| in [0,8] over the table
    localparam int FRAC_BITS        = SAMPLE_BITS + 2 - $clog2(TANH_TABLE_DEPTH);

    localparam int MIX_FULL   = 65536;
    localparam int MIX_BYPASS = 66;

    // 16/depth in Q.32, the exponent step between table entries
    localparam longint unsigned TANH_STEP = (64'd16 << 32) / TANH_TABLE_DEPTH;

    // register indexes
    localparam logic [2:0] REG_DRIVE_TYPE  = 3'd0;
    localparam logic [2:0] REG_DRIVE_GAIN  = 3'd1;
    localparam logic [2:0] REG_POST_GAIN   = 3'd2;
    localparam logic [2:0] REG_MIX_TARGET  = 3'd3;
    localparam logic [2:0] REG_RAMP_LENGTH = 3'd4;

    // shaping modes
    localparam logic [1:0] TYPE_SOFT = 2'd0;
    localparam logic [1:0] TYPE_HARD = 2'd1;
    localparam logic [1:0] TYPE_FOLD = 2'd2;

    typedef logic [SAMPLE_BITS-1:0] t_rom [0:TANH_TABLE_DEPTH];

    // shift and subtract quotient, used only while the table is built
    function automatic longint unsigned udiv(longint unsigned n, longint unsigned d);
        longint unsigned q;
        longint unsigned rm;
        q  = 64'd0;
        rm = 64'd0;
        for (int b = 63; b >= 0; b--) begin
            rm = (rm << 1) | ((n >> b) & 64'd1);
            q  = q << 1;
            if (rm >= d) begin
                rm = rm - d;
                q  = q | 64'd1;
            end
        end
        return q;
    endfunction

    // tanh(t) for t = 8*i/depth, entry = (1-e)/(1+e), e = exp(-16/depth)^i, Q.32 math
    function automatic t_rom build_tanh();
        longint unsigned q32;
        longint unsigned u;
        longint unsigned sum;
        longint unsigned term;
        longint unsigned p;
        longint unsigned den;
        t_rom            r;
        q32  = 64'd1 << 32;
        u    = TANH_STEP;
        sum  = q32;
        term = q32;
        p    = q32;
        for (int k = 1; k <= 24; k++) begin
            term = ((term * u) + (q32 >> 1)) >> 32;
            term = udiv(term, 64'(k));
            if ((k & 1) == 1) sum = sum - term;
            else              sum = sum + term;
        end
        for (int i = 0; i <= TANH_TABLE_DEPTH; i++) begin
            den  = q32 + p;
            r[i] = SAMPLE_BITS'(udiv(((q32 - p) << (SAMPLE_BITS - 1)) + (den >> 1), den));
            p    = ((p * sum) + (q32 >> 1)) >> 32;
        end
        return r;
    endfunction

    localparam t_rom TANH_ROM = build_tanh();

endpackage

### rtl/core/drive_waveshaper_mix_unit.sv
// ----------------------------------------------------------------------------
// drive_waveshaper_mix_unit: stereo drive, waveshaper and dry/wet mix
// One shared multiplier under a sequencer processes both channels in turn.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid / o_in_ready) takes one stereo frame of signed
//   Q1.23 samples. Output channel (o_out_valid / i_out_ready) returns one
//   frame of saturated Q1.23 samples per input frame, in order.
//   The APB port writes and reads the five registers at byte address 4*i.
//   Each frame runs through the sequencer one channel after the other: a soft
//   tanh frame takes 10 multiplier-sequencer steps per channel (the single
//   multiplier visited five times and two table reads), hard clip and fold
//   take 6 steps per channel, and then comes an output step; a bypassed
//   frame goes straight to the output step. A new frame is taken only after
//   the last one has left the sequencer.
//   A write of mix_target that starts a ramp runs a bit-serial divide for
//   the ramp step; o_in_ready stays low until it finishes.
//   Reset clears registers to their defaults and the mix state to zero.
//   A stalled receiver holds the output register; one more frame may be
//   processed and then waits until the output register frees.
// ----------------------------------------------------------------------------
module drive_waveshaper_mix_unit (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_ready,
    input  logic signed [dwm_pkg::SAMPLE_BITS-1:0] i_left_sample,
    input  logic signed [dwm_pkg::SAMPLE_BITS-1:0] i_right_sample,
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output logic signed [dwm_pkg::SAMPLE_BITS-1:0] o_left_out,
    output logic signed [dwm_pkg::SAMPLE_BITS-1:0] o_right_out,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [4:0]                         paddr,
    input  logic [31:0]                        pwdata,
    output logic [31:0]                        prdata,
    output logic                               pready
);

    localparam int SB = dwm_pkg::SAMPLE_BITS;
    localparam int IDX_W = dwm_pkg::IDX_BITS;

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_DRV  = 4'd1;
    localparam logic [3:0] S_SHP  = 4'd2;
    localparam logic [3:0] S_LO   = 4'd3;
    localparam logic [3:0] S_HI   = 4'd4;
    localparam logic [3:0] S_INT  = 4'd5;
    localparam logic [3:0] S_SFN  = 4'd6;
    localparam logic [3:0] S_WET  = 4'd7;
    localparam logic [3:0] S_DRY  = 4'd8;
    localparam logic [3:0] S_WM   = 4'd9;
    localparam logic [3:0] S_SUM  = 4'd10;
    localparam logic [3:0] S_DONE = 4'd11;

    // registers
    logic [1:0]  r_type;
    logic [23:0] r_gain;
    logic [19:0] r_post;
    logic [16:0] r_target;
    logic [15:0] r_len;
    // mix state
    logic [16:0]        r_cur;
    logic signed [17:0] r_step;
    logic [15:0]        r_rem;
    // ramp step divider
    logic        r_div_busy;
    logic        r_div_neg;
    logic [4:0]  r_div_cnt;
    logic [15:0] r_drem;
    logic [16:0] r_quo;
    // sequencer
    logic [3:0]  r_state;
    logic        r_ch;
    logic        r_ov;
    logic signed [SB-1:0] r_xl, r_xr, r_res_l, r_res_r, r_ol, r_or;
    logic signed [54:0] r_p;
    logic signed [47:0] r_acc;
    logic signed [24:0] r_s;
    logic signed [29:0] r_wet;
    logic [IDX_W-1:0]   r_idx;
    logic [dwm_pkg::FRAC_BITS-1:0] r_f;
    logic        r_neg;
    logic [SB-1:0] r_lo, r_hi;

    logic wr_en;
    assign wr_en = psel && penable && pwrite;
    assign pready = 1'b1;

    always_comb begin
        unique case (paddr[4:2])
            dwm_pkg::REG_DRIVE_TYPE:  prdata = {30'd0, r_type};
            dwm_pkg::REG_DRIVE_GAIN:  prdata = {8'd0, r_gain};
            dwm_pkg::REG_POST_GAIN:   prdata = {12'd0, r_post};
            dwm_pkg::REG_MIX_TARGET:  prdata = {15'd0, r_target};
            dwm_pkg::REG_RAMP_LENGTH: prdata = {16'd0, r_len};
            default:                  prdata = 32'd0;
        endcase
    end

    // clamped target of a write and the ramp distance
    logic [16:0]        wr_tgt;
    logic signed [17:0] wr_diff;
    assign wr_tgt  = (pwdata[16:0] > 17'(dwm_pkg::MIX_FULL)) ? 17'(dwm_pkg::MIX_FULL)
                                                            : pwdata[16:0];
    assign wr_diff = $signed({1'b0, wr_tgt}) - $signed({1'b0, r_cur});

    logic [16:0] div_sh;
    assign div_sh = {r_drem, r_quo[16]};

    // shared multiplier operand select
    logic signed [SB-1:0] cur_x;
    logic signed [29:0]   mul_a;
    logic signed [24:0]   mul_b;
    logic [17:0]          dry_w;
    assign cur_x = r_ch ? r_xr : r_xl;
    assign dry_w = 18'(dwm_pkg::MIX_FULL) - {1'b0, r_cur};

    always_comb begin
        unique case (r_state)
            S_DRV: begin
                mul_a = 30'(cur_x);
                mul_b = $signed({1'b0, r_gain});
            end
            S_INT: begin
                mul_a = $signed({6'd0, r_hi - r_lo});
                mul_b = $signed({7'd0, r_f});
            end
            S_WET: begin
                mul_a = 30'(r_s);
                mul_b = $signed({5'd0, r_post});
            end
            S_DRY: begin
                mul_a = 30'(cur_x);
                mul_b = $signed({7'd0, dry_w});
            end
            S_WM: begin
                mul_a = r_wet;
                mul_b = $signed({8'd0, r_cur});
            end
            default: begin
                mul_a = 30'sd0;
                mul_b = 25'sd0;
            end
        endcase
    end

    // driven value, rounded half away from zero
    logic signed [48:0] y_t;
    logic signed [31:0] y;
    logic [31:0]        y_mag;
    logic [31:0]        y_idx;
    assign y_t   = 49'(r_p[47:0]) + 49'sd32768 - 49'(r_p[47]);
    assign y     = y_t[47:16];
    assign y_mag = y[31] ? 32'(-y) : 32'(y);
    assign y_idx = y_mag >> dwm_pkg::FRAC_BITS;

    logic signed [24:0] hard_s;
    logic [24:0]        fold_m, fold_r;
    logic signed [24:0] fold_s;
    assign hard_s = (y > 32'sd8388608)  ?  25'sd8388608 :
                    (y < -32'sd8388608) ? -25'sd8388608 : y[24:0];
    assign fold_m = y[24:0] + 25'd8388608;
    assign fold_r = (fold_m > 25'd16777216) ? (25'd0 - fold_m) : fold_m;
    assign fold_s = $signed(fold_r - 25'd8388608);

    // table read, one address per cycle
    logic [IDX_W-1:0] rom_addr;
    logic [SB-1:0]    rom_q;
    assign rom_addr = (r_state == S_LO || r_idx == IDX_W'(dwm_pkg::TANH_TABLE_DEPTH))
                      ? r_idx : r_idx + 1'b1;
    assign rom_q    = dwm_pkg::TANH_ROM[rom_addr];

    logic [SB-1:0]      soft_v;
    logic [41:0]        soft_t;
    assign soft_t = r_p[41:0] + 42'd131072;
    assign soft_v = r_lo + SB'(soft_t >> dwm_pkg::FRAC_BITS);

    logic signed [45:0] wet_t;
    assign wet_t = 46'($signed(r_p[44:0])) + 46'sd32768 - 46'(r_p[44]);

    logic signed [48:0] sum;
    logic signed [48:0] sum_t;
    logic signed [32:0] o_val;
    logic signed [SB-1:0] o_sat;
    assign sum   = 49'(r_acc) + 49'($signed(r_p[47:0]));
    assign sum_t = sum + 49'sd32768 - 49'(sum[48]);
    assign o_val = sum_t[48:16];
    assign o_sat = (o_val > 33'sd8388607)  ? 24'sh7FFFFF :
                   (o_val < -33'sd8388608) ? 24'sh800000 : o_val[SB-1:0];

    logic in_acc;
    assign o_in_ready  = (r_state == S_IDLE) && !r_div_busy;
    assign in_acc      = i_in_valid && o_in_ready;
    assign o_out_valid = r_ov;
    assign o_left_out  = r_ol;
    assign o_right_out = r_or;

    // datapath registers
    always_ff @(posedge i_clk) begin
        r_p <= 55'(mul_a * mul_b);
        if (in_acc) begin
            r_xl    <= i_left_sample;
            r_xr    <= i_right_sample;
            r_res_l <= i_left_sample;
            r_res_r <= i_right_sample;
        end
        unique case (r_state)
            S_SHP: begin
                r_neg <= y[31];
                if (y_idx >= 32'(dwm_pkg::TANH_TABLE_DEPTH)) begin
                    r_idx <= IDX_W'(dwm_pkg::TANH_TABLE_DEPTH);
                    r_f   <= '0;
                end else begin
                    r_idx <= IDX_W'(y_idx);
                    r_f   <= y_mag[dwm_pkg::FRAC_BITS-1:0];
                end
                unique case (r_type)
                    dwm_pkg::TYPE_SOFT: r_s <= 25'sd0;
                    dwm_pkg::TYPE_HARD: r_s <= hard_s;
                    dwm_pkg::TYPE_FOLD: r_s <= fold_s;
                    default:            r_s <= 25'(cur_x);
                endcase
            end
            S_LO:  r_lo <= rom_q;
            S_HI:  r_hi <= rom_q;
            S_SFN: r_s  <= r_neg ? -$signed({1'b0, soft_v}) : $signed({1'b0, soft_v});
            S_DRY: r_wet <= 30'(wet_t[45:16]);
            S_WM:  r_acc <= r_p[47:0];
            S_SUM: begin
                if (r_ch) r_res_r <= o_sat;
                else      r_res_l <= o_sat;
            end
            default: ;
        endcase
        if (r_state == S_DONE && (!r_ov || i_out_ready)) begin
            r_ol <= r_res_l;
            r_or <= r_res_r;
        end
    end

    // control, registers and mix state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_ch       <= 1'b0;
            r_ov       <= 1'b0;
            r_type     <= dwm_pkg::TYPE_SOFT;
            r_gain     <= 24'd65536;
            r_post     <= 20'd65536;
            r_target   <= 17'd0;
            r_len      <= 16'd240;
            r_cur      <= 17'd0;
            r_step     <= 18'sd0;
            r_rem      <= 16'd0;
            r_div_busy <= 1'b0;
            r_div_neg  <= 1'b0;
            r_div_cnt  <= 5'd0;
            r_drem     <= 16'd0;
            r_quo      <= 17'd0;
        end else begin
            if (r_ov && i_out_ready) r_ov <= 1'b0;

            // restoring divide, one quotient bit per cycle
            if (r_div_busy) begin
                if (div_sh >= {1'b0, r_len}) begin
                    r_drem <= 16'(div_sh - {1'b0, r_len});
                    r_quo  <= {r_quo[15:0], 1'b1};
                end else begin
                    r_drem <= div_sh[15:0];
                    r_quo  <= {r_quo[15:0], 1'b0};
                end
                r_div_cnt <= r_div_cnt - 1'b1;
                if (r_div_cnt == 5'd1) begin
                    r_div_busy <= 1'b0;
                    r_step <= r_div_neg ? -$signed({1'b0, r_quo[15:0], div_sh >= {1'b0, r_len}})
                                        :  $signed({1'b0, r_quo[15:0], div_sh >= {1'b0, r_len}});
                end
            end

            if (wr_en) begin
                unique case (paddr[4:2])
                    dwm_pkg::REG_DRIVE_TYPE: r_type <= pwdata[1:0];
                    dwm_pkg::REG_DRIVE_GAIN: r_gain <= pwdata[23:0];
                    dwm_pkg::REG_POST_GAIN:  r_post <= pwdata[19:0];
                    dwm_pkg::REG_MIX_TARGET: begin
                        if (wr_tgt != r_target) begin
                            r_target <= wr_tgt;
                            if (r_len == 16'd0) begin
                                r_cur      <= wr_tgt;
                                r_step     <= 18'sd0;
                                r_rem      <= 16'd0;
                                r_div_busy <= 1'b0;
                            end else begin
                                r_rem      <= r_len;
                                r_div_busy <= 1'b1;
                                r_div_neg  <= wr_diff[17];
                                r_div_cnt  <= 5'd17;
                                r_drem     <= 16'd0;
                                r_quo      <= wr_diff[17] ? 17'(-wr_diff) : wr_diff[16:0];
                            end
                        end
                    end
                    dwm_pkg::REG_RAMP_LENGTH: begin
                        r_len      <= pwdata[15:0];
                        r_cur      <= r_target;
                        r_step     <= 18'sd0;
                        r_rem      <= 16'd0;
                        r_div_busy <= 1'b0;
                    end
                    default: ;
                endcase
            end

            unique case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_ch <= 1'b0;
                        if (r_rem == 16'd0 && r_target < 17'(dwm_pkg::MIX_BYPASS)) begin
                            r_cur   <= r_target;
                            r_state <= S_DONE;
                        end else begin
                            if (r_rem != 16'd0) begin
                                r_rem <= r_rem - 1'b1;
                                if (r_rem == 16'd1) r_cur <= r_target;
                                else r_cur <= 17'($signed({1'b0, r_cur}) + r_step);
                            end
                            r_state <= S_DRV;
                        end
                    end
                end
                S_DRV: r_state <= S_SHP;
                S_SHP: r_state <= (r_type == dwm_pkg::TYPE_SOFT) ? S_LO : S_WET;
                S_LO:  r_state <= S_HI;
                S_HI:  r_state <= S_INT;
                S_INT: r_state <= S_SFN;
                S_SFN: r_state <= S_WET;
                S_WET: r_state <= S_DRY;
                S_DRY: r_state <= S_WM;
                S_WM:  r_state <= S_SUM;
                S_SUM: begin
                    if (r_ch) begin
                        r_state <= S_DONE;
                    end else begin
                        r_ch    <= 1'b1;
                        r_state <= S_DRV;
                    end
                end
                S_DONE: begin
                    if (!r_ov || i_out_ready) begin
                        r_ov    <= 1'b1;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

### rtl/core/dwm_checker.sv
// ----------------------------------------------------------------------------
// dwm_checker: port-level checks for the drive / waveshaper / mix block
// Watches the frame channels and the register port over time.
// ----------------------------------------------------------------------------
module dwm_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        o_in_ready,
    input logic        o_out_valid,
    input logic        i_out_ready,
    input logic [23:0] o_left_out,
    input logic [23:0] o_right_out,
    input logic        pready
);

    // a stalled output item holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_left_out)
                                        && $stable(o_right_out))
        else $error("output item changed while stalled");

    // one item at a time through the sequencer
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("input taken again while item in flight");

    // no output item right after reset
    a_rst: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

    // output valid rises only after o_in_ready was low
    a_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> !$past(o_in_ready))
        else $error("output item with no input item");

    a_pready: assert property (@(posedge i_clk) pready)
        else $error("pready low");

endmodule

bind drive_waveshaper_mix_unit dwm_checker u_dwm_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_left_out  (o_left_out),
    .o_right_out (o_right_out),
    .pready      (pready)
);
